// ===== rtl/core/adc_distance_to_servo_duty_unit_defines.svh =====
// assertion macros for the adc distance to servo duty unit
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef ADC_DISTANCE_TO_SERVO_DUTY_UNIT_DEFINES_SVH
`define ADC_DISTANCE_TO_SERVO_DUTY_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ADSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ADSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/adsd_pkg.sv =====
// shared widths, breakpoint tables and register codes for the distance to duty unit
// no dependencies
`timescale 1ns / 1ps

package adsd_pkg;

  // field widths
  localparam int ADC_W   = 16;
  localparam int DIST_W  = 13;
  localparam int OFF_W   = 12;
  localparam int PULSE_W = 16;
  localparam int DUTY_W  = 16;
  localparam int CFG_IDX_W = 2;

  // breakpoint table, converter value descending, distance ascending
  localparam int TABLE_POINTS = 6;
  localparam int unsigned ADC_PTS [TABLE_POINTS] = '{2079, 1267, 773, 687, 501, 440};
  localparam int unsigned MM_PTS  [TABLE_POINTS] = '{50, 100, 150, 200, 250, 300};
  // widest segment span and per-segment distance step both fit here
  localparam int SEG_W = 10;

  // interpolation divide by a segment span through its reciprocal
  localparam int SEG_RECIP_SH = 30;
  localparam int SEG_RECIP_W  = 25;
  localparam int SEG_PROD_W   = 2*SEG_W + SEG_RECIP_W;

  // rounded-up reciprocal of a constant span, elaboration only
  function automatic logic [SEG_RECIP_W-1:0] seg_recip(input int unsigned span);
    return SEG_RECIP_W'(((64'd1 << SEG_RECIP_SH) + 64'(span) - 64'd1) / 64'(span));
  endfunction

  localparam logic [SEG_RECIP_W-1:0] SEG_RECIP [TABLE_POINTS-1] = '{
    seg_recip(ADC_PTS[0] - ADC_PTS[1]),
    seg_recip(ADC_PTS[1] - ADC_PTS[2]),
    seg_recip(ADC_PTS[2] - ADC_PTS[3]),
    seg_recip(ADC_PTS[3] - ADC_PTS[4]),
    seg_recip(ADC_PTS[4] - ADC_PTS[5])
  };

  // distance limits in 1/16 mm
  localparam int unsigned DIST_LO_Q4   = 800;
  localparam int unsigned DIST_HI_Q4   = 4800;
  localparam int unsigned DIST_SPAN_Q4 = DIST_HI_Q4 - DIST_LO_Q4;

  // divide by the distance span: shift out the power of two, then reciprocal
  localparam int PROD_W   = OFF_W + PULSE_W;
  localparam int PRE_SH   = 5;
  localparam int N_W      = PROD_W - PRE_SH;
  localparam int unsigned RDIV = DIST_SPAN_Q4 >> PRE_SH;
  localparam int RECIP_SH = 30;
  localparam int RECIP_W  = 24;
  localparam longint unsigned RECIP_M = ((64'd1 << RECIP_SH) + RDIV - 1) / RDIV;
  localparam int RPROD_W  = N_W + RECIP_W;

  // register reset values
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2000;
  localparam logic [PULSE_W-1:0] PERIOD_RST    = 16'd20000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PULSE = 2'd0,
    REG_MAX_PULSE = 2'd1,
    REG_PERIOD    = 2'd2
  } cfg_reg_e;

endpackage

// ===== rtl/core/adsd_interp_front.sv =====
// segment search, numerator build and reciprocal divide for the distance interpolation
// three stages; depends on adsd_pkg
`timescale 1ns / 1ps

module adsd_interp_front
  import adsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [ADC_W-1:0]     adc_sample_i,
  output logic                 valid_o,
  output logic [SEG_W-1:0]     quot_o,
  output logic [OFF_W-1:0]     boff_o
);

  logic [SEG_W-1:0]       diff_d, delta_d;
  logic [SEG_RECIP_W-1:0] recip_d;
  logic [OFF_W-1:0]       boff_d;
  logic                   v1_q;
  logic [SEG_W-1:0]       diff_q, delta_q;
  logic [SEG_RECIP_W-1:0] recip1_q, recip2_q;
  logic [OFF_W-1:0]       boff1_q, boff2_q, boff3_q;
  logic [2*SEG_W-1:0]     num_d;
  logic                   v2_q;
  logic [2*SEG_W-1:0]     num_q;
  logic [SEG_PROD_W-1:0]  qprod;
  logic                   v3_q;
  logic [SEG_W-1:0]       quot_q;

  // segment select; clamped samples give a zero numerator
  always_comb begin
    diff_d  = '0;
    recip_d = '0;
    delta_d = '0;
    boff_d  = '0;
    if (32'(adc_sample_i) >= ADC_PTS[0]) begin
      boff_d = '0;
    end else if (32'(adc_sample_i) <= ADC_PTS[TABLE_POINTS-1]) begin
      boff_d = OFF_W'(DIST_SPAN_Q4);
    end else begin
      // walk downwards so the last match, the lowest-index segment, wins
      for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
        if (32'(adc_sample_i) <= ADC_PTS[i] && 32'(adc_sample_i) >= ADC_PTS[i+1]) begin
          diff_d  = SEG_W'(ADC_PTS[i] - 32'(adc_sample_i));
          recip_d = SEG_RECIP[i];
          delta_d = SEG_W'((MM_PTS[i+1] - MM_PTS[i]) * 16);
          boff_d  = OFF_W'(MM_PTS[i] * 16 - DIST_LO_Q4);
        end
      end
    end
  end

  // stage one: segment data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q   <= diff_d;
    recip1_q <= recip_d;
    delta_q  <= delta_d;
    boff1_q  <= boff_d;
  end

  // scaled offset into the segment
  assign num_d = (2*SEG_W)'(delta_q) * (2*SEG_W)'(diff_q);

  // stage two: numerator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    recip2_q <= recip1_q;
    boff2_q  <= boff1_q;
  end

  // numerator times the span reciprocal
  assign qprod = SEG_PROD_W'(num_q) * SEG_PROD_W'(recip2_q);

  // stage three: quotient
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= qprod[SEG_RECIP_SH+SEG_W-1:SEG_RECIP_SH];
    boff3_q <= boff2_q;
  end

  assign valid_o = v3_q;
  assign quot_o  = quot_q;
  assign boff_o  = boff3_q;

endmodule

// ===== rtl/core/adsd_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating on overflow
// depends on adsd_pkg only for house conventions
`timescale 1ns / 1ps

module adsd_div_pipe
  import adsd_pkg::*;
#(
  parameter int QW = 16,
  parameter int DW = 16,
  parameter int SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q [QW+1];
  logic          ovf_q   [QW+1];
  logic [DW-1:0] rem_q   [QW+1];
  logic [QW-1:0] sh_q    [QW+1];
  logic [DW-1:0] den_q   [QW+1];
  logic [SW-1:0] side_q  [QW+1];

  // entry stage: upper half at or above divisor means the quotient overflows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q[0]  <= (num_hi_i >= den_i);
    rem_q[0]  <= num_hi_i;
    sh_q[0]   <= num_lo_i;
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
  end

  // one restoring step per stage; numerator bits shift out, quotient bits in
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_q[k], sh_q[k][QW-1]};
    assign ge    = (trial >= {1'b0, den_q[k]});
    assign diff  = trial - {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[k+1]  <= ovf_q[k];
      rem_q[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh_q[k+1]   <= {sh_q[k][QW-2:0], ge};
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = valid_q[QW];
  assign quot_o  = ovf_q[QW] ? '1 : sh_q[QW];
  assign side_o  = side_q[QW];

endmodule

// ===== rtl/core/adsd_pulse_map.sv =====
// distance to pulse width mapping, five stages, and duty numerator build
// depends on adsd_pkg
`timescale 1ns / 1ps

module adsd_pulse_map
  import adsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [SEG_W-1:0]   quot_i,
  input  logic [OFF_W-1:0]   boff_i,
  input  logic [PULSE_W-1:0] min_pulse_i,
  input  logic [PULSE_W-1:0] max_pulse_i,
  output logic               valid_o,
  output logic [DIST_W-1:0]  distance_q4_o,
  output logic [PULSE_W-1:0] pulse_us_o,
  output logic [DUTY_W-1:0]  num_hi_o,
  output logic [DUTY_W-1:0]  num_lo_o
);

  logic               v_q [5];
  logic [OFF_W-1:0]   off1_q, off2_q, off3_q, off4_q;
  logic [PULSE_W-1:0] span;
  logic [PROD_W-1:0]  prod_d, prod_q;
  logic               swap2_q, swap3_q;
  logic [RPROD_W-1:0] rprod;
  logic [PULSE_W-1:0] q3_q;
  logic [PULSE_W:0]   sum;
  logic [PULSE_W-1:0] pulse_d, pulse4_q;
  logic [DIST_W-1:0]  dist5_q;
  logic [PULSE_W-1:0] pulse5_q;
  logic [DUTY_W-1:0]  hi5_q, lo5_q;

  // valid bits travel alongside
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < 5; i++) v_q[i] <= v_q[i-1];
    end
  end

  // stage one: distance offset above the near limit
  always_ff @(posedge clk_i) begin
    off1_q <= boff_i + OFF_W'(quot_i);
  end

  // stage two: offset times pulse span
  assign span   = max_pulse_i - min_pulse_i;
  assign prod_d = PROD_W'(off1_q) * PROD_W'(span);

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    off2_q  <= off1_q;
    swap2_q <= (max_pulse_i < min_pulse_i);
  end

  // stage three: divide by the distance span through the reciprocal
  assign rprod = RPROD_W'(prod_q[PROD_W-1:PRE_SH]) * RPROD_W'(RECIP_M[RECIP_W-1:0]);

  always_ff @(posedge clk_i) begin
    q3_q    <= rprod[RECIP_SH+PULSE_W-1:RECIP_SH];
    off3_q  <= off2_q;
    swap3_q <= swap2_q;
  end

  // stage four: add minimum, clamp to maximum; maximum also when it lies below minimum
  assign sum = {1'b0, min_pulse_i} + {1'b0, q3_q};

  always_comb begin
    if (swap3_q || sum > {1'b0, max_pulse_i}) begin
      pulse_d = max_pulse_i;
    end else begin
      pulse_d = sum[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pulse4_q <= pulse_d;
    off4_q   <= off3_q;
  end

  // stage five: pulse times full scale split in halves, distance restored
  always_ff @(posedge clk_i) begin
    hi5_q    <= (pulse4_q == '0) ? '0 : DUTY_W'(pulse4_q - PULSE_W'(1));
    lo5_q    <= DUTY_W'(-pulse4_q);
    pulse5_q <= pulse4_q;
    dist5_q  <= DIST_W'(off4_q) + DIST_W'(DIST_LO_Q4);
  end

  assign valid_o       = v_q[4];
  assign distance_q4_o = dist5_q;
  assign pulse_us_o    = pulse5_q;
  assign num_hi_o      = hi5_q;
  assign num_lo_o      = lo5_q;

endmodule

// ===== rtl/core/adc_distance_to_servo_duty_unit.sv =====
// top level: converter sample to distance, servo pulse and pwm duty
// depends on adsd_pkg, adsd_interp_front, adsd_div_pipe, adsd_pulse_map
//
//   port group   direction  handshake                    payload
//   item in      in         start / busy                 adc_sample_i
//   result out   out        done_o strobe, no back-off   distance_q4_o, pulse_us_o, duty_o
//   register     in         cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// one item enters every cycle while busy is low, through interpolation, mapping,
// duty divider pipeline and result register. reset clears the valid bits and loads
// register reset values; busy and cfg_ready_o change in the cycle after release.
// results cannot be held off, so nothing ever stalls.
`timescale 1ns / 1ps
`include "adc_distance_to_servo_duty_unit_defines.svh"

module adc_distance_to_servo_duty_unit
  import adsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADC_W-1:0]     adc_sample_i,
  output logic                 done_o,
  output logic [DIST_W-1:0]    distance_q4_o,
  output logic [PULSE_W-1:0]   pulse_us_o,
  output logic [DUTY_W-1:0]    duty_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PULSE_W-1:0]   cfg_data_i
);

  localparam int LAT = 3 + 5 + (DUTY_W + 1) + 1;
  localparam int SIDE_W = DIST_W + PULSE_W;

  logic               busy_q;
  logic [PULSE_W-1:0] min_q, max_q, period_q;
  logic               accept;

  logic               fe_valid;
  logic [SEG_W-1:0]   fe_quot;
  logic [OFF_W-1:0]   fe_boff;

  logic               pm_valid;
  logic [DIST_W-1:0]  pm_dist;
  logic [PULSE_W-1:0] pm_pulse;
  logic [DUTY_W-1:0]  pm_hi, pm_lo;

  logic               dd_valid;
  logic [DUTY_W-1:0]  dd_quot;
  logic [SIDE_W-1:0]  dd_side;

  logic               done_q;
  logic [DIST_W-1:0]  dist_q;
  logic [PULSE_W-1:0] pulse_q;
  logic [DUTY_W-1:0]  duty_q;

  // ready in the cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy        = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign accept      = start & ~busy_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= MIN_PULSE_RST;
      max_q    <= MAX_PULSE_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MIN_PULSE: min_q    <= cfg_data_i;
        REG_MAX_PULSE: max_q    <= cfg_data_i;
        REG_PERIOD:    period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // segment search and interpolation divide
  adsd_interp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .adc_sample_i (adc_sample_i),
    .valid_o      (fe_valid),
    .quot_o       (fe_quot),
    .boff_o       (fe_boff)
  );

  // distance to pulse
  adsd_pulse_map u_pulse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (fe_valid),
    .quot_i        (fe_quot),
    .boff_i        (fe_boff),
    .min_pulse_i   (min_q),
    .max_pulse_i   (max_q),
    .valid_o       (pm_valid),
    .distance_q4_o (pm_dist),
    .pulse_us_o    (pm_pulse),
    .num_hi_o      (pm_hi),
    .num_lo_o      (pm_lo)
  );

  // duty divide by the period, saturating to full scale
  adsd_div_pipe #(
    .QW (DUTY_W),
    .DW (PULSE_W),
    .SW (SIDE_W)
  ) u_duty_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (pm_valid),
    .num_hi_i (pm_hi),
    .num_lo_i (pm_lo),
    .den_i    (period_q),
    .side_i   ({pm_dist, pm_pulse}),
    .valid_o  (dd_valid),
    .quot_o   (dd_quot),
    .side_o   (dd_side)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dd_side[SIDE_W-1:PULSE_W];
    pulse_q <= dd_side[PULSE_W-1:0];
    duty_q  <= dd_quot;
  end

  assign done_o        = done_q;
  assign distance_q4_o = dist_q;
  assign pulse_us_o    = pulse_q;
  assign duty_o        = duty_q;

  // checks
  `ADSD_ASSERT_IMP(a_done_latency, done_o, $past(accept, LAT), "result without item")
  `ADSD_ASSERT_IMP(a_pulse_range, done_o && (max_q >= min_q),
    (pulse_us_o >= min_q) && (pulse_us_o <= max_q), "pulse outside configured range")
  `ADSD_ASSERT_IMP(a_zero_period, done_o && (period_q == '0), duty_o == '1,
    "zero period must give full scale")
  `ADSD_ASSERT_NXT(a_cfg_unused,
    cfg_valid_i && cfg_ready_o && (cfg_index_i != REG_MIN_PULSE) &&
    (cfg_index_i != REG_MAX_PULSE) && (cfg_index_i != REG_PERIOD),
    $stable(min_q) && $stable(max_q) && $stable(period_q), "unused index wrote a register")

endmodule
